### rtl/core/hbmt_pkg.sv
// Shared types and constants for the heartbeat membership table.
// No dependencies.
package hbmt_pkg;
	localparam int TableDepth = 16;
	localparam int IdxW = $clog2(TableDepth);
	localparam int CntW = $clog2(TableDepth + 1);

	localparam logic [1:0] REQ_JOIN   = 2'd0;
	localparam logic [1:0] REQ_REPLY  = 2'd1;
	localparam logic [1:0] REQ_GOSSIP = 2'd2;
	localparam logic [1:0] REQ_TICK   = 2'd3;

	localparam logic [2:0] EV_NONE    = 3'd0;
	localparam logic [2:0] EV_ADDED   = 3'd1;
	localparam logic [2:0] EV_REMOVED = 3'd2;
	localparam logic [2:0] EV_LIST    = 3'd3;
	localparam logic [2:0] EV_FULL    = 3'd4;

	localparam logic [1:0] CFG_COORD  = 2'd0;
	localparam logic [1:0] CFG_SELF   = 2'd1;
	localparam logic [1:0] CFG_FAIL   = 2'd2;
	localparam logic [1:0] CFG_REMOVE = 2'd3;

	localparam logic [7:0] FAIL_TMO_RST   = 8'd5;
	localparam logic [7:0] REMOVE_TMO_RST = 8'd20;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [47:0] entry_addr;
		logic [31:0] entry_heartbeat;
		logic        first_entry;
		logic [31:0] now;
	} req_t;

	typedef struct packed {
		logic [2:0]  event_kind;
		logic [47:0] out_addr;
		logic [31:0] out_heartbeat;
		logic        last;
	} rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SEARCH,   // walk slots: match and first free
		ST_DECIDE,
		ST_UPDATE,   // gossip heartbeat compare and write
		ST_AGE,      // tick: one slot per cycle unless the output stalls
		ST_SELF,     // own list entry
		ST_LIST,     // one slot per cycle unless the output stalls
		ST_EMIT      // single event, then done or own entry for a join insert
	} state_t;
endpackage

### rtl/core/heartbeat_membership_table_top.sv
// Heartbeat membership table: sequencer, slot store and output register.
// Depends on hbmt_pkg.
//
// Usage:
//   Input channel req (req_valid/req_stall) carries one request item.
//   Output channel rsp (rsp_valid/rsp_stall) carries result items; the final
//   result of an item has last set. cfg (cfg_valid/cfg_ready) writes the
//   registers coordinator_mode, self_addr, fail_timeout, remove_timeout.
//   One item at a time: req_stall is high from acceptance until the
//   sequencer is idle again, which for an item with results is when its
//   final result is loaded into the output register. Every item first walks
//   all 16 slots for the address match and free slot, then decides: an
//   ignored item ends there without a result, a gossip update compares and
//   writes its slot, an insert or a full table emits one event. A join that
//   inserts adds its event, own entry and a list walk. A tick ages the slots,
//   then sends its own entry and walks the list. Each result is registered
//   before it reaches rsp. The slot walk goes through a single compare unit.
//   A stalled output holds its result and the sequencer waits before its next result.
//   Reset clears slot valid bits, own heartbeat, joined and the registers
//   (timeouts to 5 and 20); slot payloads are unknown until written.
module heartbeat_membership_table_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  hbmt_pkg::req_t    req,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output hbmt_pkg::rsp_t    rsp,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [47:0]       cfg_data
);
	localparam int IW = hbmt_pkg::IdxW;
	localparam int CW = hbmt_pkg::CntW;

	logic        coord_q, joined_q;
	logic [47:0] self_q;
	logic [7:0]  fail_q, remove_q;
	logic [31:0] own_hb_q;

	logic [hbmt_pkg::TableDepth-1:0] valid_q, failed_q;
	logic [47:0] addr_mem [hbmt_pkg::TableDepth];
	logic [31:0] hb_mem   [hbmt_pkg::TableDepth];
	logic [31:0] stamp_mem[hbmt_pkg::TableDepth];

	hbmt_pkg::state_t state_q, state_d;
	hbmt_pkg::req_t   req_q;
	logic [CW-1:0]    cnt_q;
	logic [IW-1:0]    idx;
	logic             found_q, free_q;
	logic [IW-1:0]    match_q, free_idx_q;
	logic             out_free;

	assign idx       = cnt_q[IW-1:0];
	assign cfg_ready = 1'b1;
	assign req_stall = (state_q != hbmt_pkg::ST_IDLE);
	assign out_free  = !rsp_valid || !rsp_stall;

	// list continuation: any remaining live slot at or after idx+1
	logic more_live;
	always_comb begin
		more_live = 1'b0;
		for (int i = 0; i < hbmt_pkg::TableDepth; i++)
			if (i > int'(idx) && valid_q[i] && !failed_q[i]) more_live = 1'b1;
	end
	logic any_live;
	assign any_live = |(valid_q & ~failed_q);

	logic last_slot;
	assign last_slot = (cnt_q == CW'(hbmt_pkg::TableDepth - 1));

	// shared compare unit: one slot per cycle while the output is not stalled
	logic        addr_eq;
	logic [32:0] lim;
	logic        expired;
	assign addr_eq = valid_q[idx] && (addr_mem[idx] == req_q.entry_addr);
	assign lim     = {1'b0, stamp_mem[idx]} +
		{25'd0, failed_q[idx] ? remove_q : fail_q};
	assign expired = {1'b0, req_q.now} > lim;

	// decision after search
	logic self_hit, active;
	assign self_hit = (req_q.entry_addr == self_q);
	always_comb begin
		unique case (req_q.req_type)
			hbmt_pkg::REQ_JOIN:   active = coord_q && !self_hit && !found_q;
			hbmt_pkg::REQ_REPLY:  active = !coord_q && !self_hit && !found_q;
			hbmt_pkg::REQ_GOSSIP: active = joined_q && !self_hit;
			default:              active = joined_q;
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			hbmt_pkg::ST_IDLE:
				if (req_valid) state_d = hbmt_pkg::ST_SEARCH;
			hbmt_pkg::ST_SEARCH:
				if (last_slot) state_d = hbmt_pkg::ST_DECIDE;
			hbmt_pkg::ST_DECIDE: begin
				if (req_q.req_type == hbmt_pkg::REQ_TICK)
					state_d = joined_q ? hbmt_pkg::ST_AGE : hbmt_pkg::ST_IDLE;
				else if (!active)
					state_d = hbmt_pkg::ST_IDLE;
				else if (req_q.req_type == hbmt_pkg::REQ_GOSSIP && found_q)
					state_d = hbmt_pkg::ST_UPDATE;
				else
					state_d = hbmt_pkg::ST_EMIT;
			end
			hbmt_pkg::ST_UPDATE: state_d = hbmt_pkg::ST_IDLE;
			hbmt_pkg::ST_AGE:
				if (out_free && last_slot) state_d = hbmt_pkg::ST_SELF;
			hbmt_pkg::ST_EMIT:
				if (out_free) state_d = (req_q.req_type == hbmt_pkg::REQ_JOIN && free_q)
					? hbmt_pkg::ST_SELF : hbmt_pkg::ST_IDLE;
			hbmt_pkg::ST_SELF:
				if (out_free) state_d = any_live ? hbmt_pkg::ST_LIST : hbmt_pkg::ST_IDLE;
			hbmt_pkg::ST_LIST:
				if (out_free && !more_live) state_d = hbmt_pkg::ST_IDLE;
			default: state_d = hbmt_pkg::ST_IDLE;
		endcase
	end

	// outputs: at most one result per cycle into the output register, when it is free
	logic        push;
	logic [2:0]  push_kind;
	logic [47:0] push_addr;
	logic [31:0] push_hb;
	logic        push_last;
	logic        age_remove;
	logic [31:0] own_hb_inc;
	assign own_hb_inc = (own_hb_q == 32'hFFFF_FFFF) ? own_hb_q : own_hb_q + 32'd1;
	assign age_remove = valid_q[idx] && failed_q[idx] && expired;
	always_comb begin
		push = 1'b0; push_kind = hbmt_pkg::EV_NONE; push_addr = '0;
		push_hb = '0; push_last = 1'b0;
		unique case (state_q)
			hbmt_pkg::ST_AGE: begin
				push = age_remove; push_kind = hbmt_pkg::EV_REMOVED;
				push_addr = addr_mem[idx];
			end
			hbmt_pkg::ST_EMIT: begin
				push = 1'b1; push_kind = free_q ? hbmt_pkg::EV_ADDED : hbmt_pkg::EV_FULL;
				push_addr = req_q.entry_addr;
				push_last = !(req_q.req_type == hbmt_pkg::REQ_JOIN && free_q);
			end
			hbmt_pkg::ST_SELF: begin
				push = 1'b1; push_kind = hbmt_pkg::EV_LIST; push_addr = self_q;
				push_hb = own_hb_q; push_last = !any_live;
			end
			hbmt_pkg::ST_LIST: begin
				push = valid_q[idx] && !failed_q[idx]; push_kind = hbmt_pkg::EV_LIST;
				push_addr = addr_mem[idx]; push_hb = hb_mem[idx]; push_last = !more_live;
			end
			default: ;
		endcase
	end

	logic [hbmt_pkg::TableDepth-1:0] reply_clr;
	assign reply_clr = (req.req_type == hbmt_pkg::REQ_REPLY && req.first_entry && !coord_q)
		? '0 : valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hbmt_pkg::ST_IDLE;
			cnt_q <= '0; valid_q <= '0; own_hb_q <= '0;
			coord_q <= 1'b0; joined_q <= 1'b0; self_q <= '0;
			fail_q <= hbmt_pkg::FAIL_TMO_RST; remove_q <= hbmt_pkg::REMOVE_TMO_RST;
			rsp_valid <= 1'b0;
			found_q <= 1'b0; free_q <= 1'b0;
			match_q <= '0; free_idx_q <= '0;
		end else begin
			state_q <= state_d;
			if (out_free) rsp_valid <= push;
			if (cfg_valid) begin
				unique case (cfg_index)
					hbmt_pkg::CFG_COORD: begin
						coord_q <= cfg_data[0];
						if (cfg_data[0]) joined_q <= 1'b1;
					end
					hbmt_pkg::CFG_SELF:   self_q   <= cfg_data;
					hbmt_pkg::CFG_FAIL:   fail_q   <= cfg_data[7:0];
					hbmt_pkg::CFG_REMOVE: remove_q <= cfg_data[7:0];
				endcase
			end
			unique case (state_q)
				hbmt_pkg::ST_IDLE: if (req_valid) begin
					cnt_q <= '0; found_q <= 1'b0; free_q <= 1'b0;
					valid_q <= reply_clr;
				end
				hbmt_pkg::ST_SEARCH: begin
					if (addr_eq) begin found_q <= 1'b1; match_q <= idx; end
					if (!valid_q[idx] && !free_q) begin free_q <= 1'b1; free_idx_q <= idx; end
					cnt_q <= last_slot ? '0 : cnt_q + CW'(1);
				end
				hbmt_pkg::ST_DECIDE: begin
					if (req_q.req_type == hbmt_pkg::REQ_REPLY && !coord_q) joined_q <= 1'b1;
					if (active && req_q.req_type != hbmt_pkg::REQ_TICK && !found_q && free_q)
						valid_q[free_idx_q] <= 1'b1;
				end
				hbmt_pkg::ST_AGE: if (out_free) begin
					if (age_remove) valid_q[idx] <= 1'b0;
					cnt_q <= last_slot ? '0 : cnt_q + CW'(1);
					if (last_slot) own_hb_q <= own_hb_inc;
				end
				hbmt_pkg::ST_EMIT:
					if (out_free && req_q.req_type == hbmt_pkg::REQ_JOIN && free_q)
						own_hb_q <= own_hb_inc;
				hbmt_pkg::ST_SELF: if (out_free) cnt_q <= '0;
				hbmt_pkg::ST_LIST: if (out_free) cnt_q <= cnt_q + CW'(1);
				default: ;
			endcase
		end
	end

	// slot payloads, failed marks, request and result registers; no reset
	always_ff @(posedge clk) begin
		if (state_q == hbmt_pkg::ST_IDLE && req_valid) req_q <= req;
		if (state_q == hbmt_pkg::ST_DECIDE && active &&
				req_q.req_type != hbmt_pkg::REQ_TICK && !found_q && free_q) begin
			addr_mem[free_idx_q]  <= req_q.entry_addr;
			hb_mem[free_idx_q]    <= req_q.entry_heartbeat;
			stamp_mem[free_idx_q] <= req_q.now;
			failed_q[free_idx_q]  <= 1'b0;
		end
		if (state_q == hbmt_pkg::ST_UPDATE && req_q.entry_heartbeat > hb_mem[match_q]) begin
			hb_mem[match_q]    <= req_q.entry_heartbeat;
			stamp_mem[match_q] <= req_q.now;
			failed_q[match_q]  <= 1'b0;
		end
		if (state_q == hbmt_pkg::ST_AGE && out_free && valid_q[idx] && !failed_q[idx]
				&& expired) begin
			stamp_mem[idx] <= req_q.now;
			failed_q[idx]  <= 1'b1;
		end
		if (out_free && push) begin
			rsp.event_kind    <= push_kind;
			rsp.out_addr      <= push_addr;
			rsp.out_heartbeat <= push_hb;
			rsp.last          <= push_last;
		end
	end
endmodule
